[src/u2u_pkg.sv]
// Package for the UTF-8 to UTF-16 stream transcoder.
// Holds the queue entry and status types, the UTF constants and the lead-byte tables.
// No dependencies.
`timescale 1ns / 1ps

package u2u_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [31:0] MAX_BMP      = 32'h0000_FFFF;
    localparam logic [31:0] MAX_UTF16    = 32'h0010_FFFF;
    localparam logic [31:0] HALF_BASE    = 32'h0001_0000;
    localparam logic [10:0] HALF_BASE_HI = 11'h040;
    localparam logic [15:0] SUR_HI_START = 16'hD800;
    localparam logic [15:0] SUR_LO_START = 16'hDC00;
    localparam logic [15:0] SUR_LO_END   = 16'hDFFF;
    localparam logic [15:0] REPL_RESET   = 16'hFFFD;

    // One finished sequence, or a terminator, waiting for the back end.
    typedef struct packed {
        logic [31:0] acc;
        logic [2:0]  trail;
        logic        eos;
    } u2u_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } u2u_qstat_t;

    function automatic logic [2:0] lead_count(input logic [7:0] b);
        logic [2:0] n;
        if (b < 8'hC0)
            n = 3'd0;
        else if (b < 8'hE0)
            n = 3'd1;
        else if (b < 8'hF0)
            n = 3'd2;
        else if (b < 8'hF8)
            n = 3'd3;
        else if (b < 8'hFC)
            n = 3'd4;
        else
            n = 3'd5;
        return n;
    endfunction

    function automatic logic [31:0] seq_offset(input logic [2:0] t);
        logic [31:0] off;
        case (t)
            3'd0:    off = 32'h0000_0000;
            3'd1:    off = 32'h0000_3080;
            3'd2:    off = 32'h000E_2080;
            3'd3:    off = 32'h03C8_2080;
            3'd4:    off = 32'hFA08_2080;
            default: off = 32'h8208_2080;
        endcase
        return off;
    endfunction

endpackage

[src/utf8_to_utf16_stream.sv]
// Streaming UTF-8 to UTF-16 transcoder, top level. Depends on u2u_pkg, u2u_front,
// u2u_fifo and u2u_back. Takes one byte per cycle while in_stall is low. A finished
// sequence is registered in the queue, then in the output register. A surrogate
// pair gives two units; the four-entry queue absorbs it. Reset clears the sequence
// state, the queue and the output, and sets the replacement unit to 0xFFFD.
`timescale 1ns / 1ps

module utf8_to_utf16_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  byte_in,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [15:0] utf16_unit,
    output logic        last_of_run,
    output logic        end_of_string,
    output logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] replacement_unit,
    input  logic        cfg_valid,
    output logic        cfg_ready
);
    import u2u_pkg::*;

    logic [15:0] repl_reg;
    logic        push;
    logic        pop;
    u2u_entry_t  push_data;
    u2u_entry_t  pop_data;
    u2u_qstat_t  qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_reg <= REPL_RESET;
        else if (cfg_valid && cfg_ready)
            repl_reg <= replacement_unit;
    end

    u2u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    u2u_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    u2u_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_data      (pop_data),
        .qstat         (qstat),
        .pop           (pop),
        .repl_unit     (repl_reg),
        .utf16_unit    (utf16_unit),
        .last_of_run   (last_of_run),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

endmodule

[src/u2u_front.sv]
// Front end of the transcoder: takes bytes and folds each sequence into an accumulator.
// Pushes one queue entry per finished sequence or terminator. Depends on u2u_pkg.
`timescale 1ns / 1ps

module u2u_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          byte_in,
    input  logic                in_valid,
    output logic                in_stall,
    input  u2u_pkg::u2u_qstat_t qstat,
    output logic                push,
    output u2u_pkg::u2u_entry_t push_data
);
    import u2u_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic [2:0]  remaining_reg, remaining_next;
    logic [2:0]  trail_reg, trail_next;
    logic        accept;
    logic [2:0]  lead;
    logic [31:0] folded;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign lead     = lead_count(byte_in);
    assign folded   = {acc_reg[25:0], 6'b0} + {24'b0, byte_in};

    always_comb
    begin
        acc_next       = acc_reg;
        remaining_next = remaining_reg;
        trail_next     = trail_reg;
        push           = 1'b0;
        push_data      = '0;
        if (accept)
        begin
            if (remaining_reg == 3'd0)
            begin
                if (byte_in == 8'h00)
                begin
                    push          = 1'b1;
                    push_data.eos = 1'b1;
                    acc_next      = '0;
                    trail_next    = '0;
                end
                else if (lead == 3'd0)
                begin
                    // A single-byte sequence finishes at once.
                    push          = 1'b1;
                    push_data.acc = {24'b0, byte_in};
                    acc_next      = '0;
                    trail_next    = '0;
                end
                else
                begin
                    acc_next       = {24'b0, byte_in};
                    remaining_next = lead;
                    trail_next     = lead;
                end
            end
            else
            begin
                remaining_next = remaining_reg - 3'd1;
                if (remaining_reg == 3'd1)
                begin
                    push            = 1'b1;
                    push_data.acc   = folded;
                    push_data.trail = trail_reg;
                    acc_next        = '0;
                    trail_next      = '0;
                end
                else
                begin
                    acc_next = folded;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            remaining_reg <= '0;
            trail_reg     <= '0;
        end
        else
        begin
            acc_reg       <= acc_next;
            remaining_reg <= remaining_next;
            trail_reg     <= trail_next;
        end
    end

endmodule

[src/u2u_fifo.sv]
// Short queue between the front and back ends of the transcoder.
// Register array with read and write pointers. Depends on u2u_pkg.
`timescale 1ns / 1ps

module u2u_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u2u_pkg::u2u_entry_t push_data,
    input  logic                pop,
    output u2u_pkg::u2u_entry_t pop_data,
    output u2u_pkg::u2u_qstat_t qstat
);
    import u2u_pkg::*;

    u2u_entry_t        slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign pop_data    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/u2u_back.sv]
// Back end of the transcoder: turns queued sequences into UTF-16 units.
// Removes the sequence offset, classifies the code point and emits one or two units.
// Depends on u2u_pkg.
`timescale 1ns / 1ps

module u2u_back (
    input  logic                clk,
    input  logic                rst_n,
    input  u2u_pkg::u2u_entry_t pop_data,
    input  u2u_pkg::u2u_qstat_t qstat,
    output logic                pop,
    input  logic [15:0]         repl_unit,
    output logic [15:0]         utf16_unit,
    output logic                last_of_run,
    output logic                end_of_string,
    output logic                out_valid,
    input  logic                out_stall
);
    import u2u_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_unit_reg, out_unit_next;
    logic        out_last_reg, out_last_next;
    logic        out_eos_reg, out_eos_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [15:0] pend_unit_reg, pend_unit_next;

    logic [31:0] ch;
    logic [10:0] hi_bits;
    logic        is_pair;
    logic [15:0] first_unit;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;
    logic        out_free;

    assign ch      = pop_data.acc - seq_offset(pop_data.trail);
    assign hi_bits = ch[20:10] - HALF_BASE_HI;
    assign hi_unit = SUR_HI_START | {6'b0, hi_bits[9:0]};
    assign lo_unit = SUR_LO_START | {6'b0, ch[9:0]};
    assign is_pair = !pop_data.eos && (ch >= HALF_BASE) && (ch <= MAX_UTF16);

    always_comb
    begin
        if (pop_data.eos)
            first_unit = 16'h0000;
        else if (ch <= MAX_BMP)
        begin
            if (ch[15:0] >= SUR_HI_START && ch[15:0] <= SUR_LO_END)
                first_unit = repl_unit;
            else
                first_unit = ch[15:0];
        end
        else if (ch > MAX_UTF16)
            first_unit = repl_unit;
        else
            first_unit = hi_unit;
    end

    // The output register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = out_free && !pend_valid_reg && !qstat.empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_unit_next   = out_unit_reg;
        out_last_next   = out_last_reg;
        out_eos_next    = out_eos_reg;
        pend_valid_next = pend_valid_reg;
        pend_unit_next  = pend_unit_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_unit_next   = pend_unit_reg;
                out_last_next   = 1'b1;
                out_eos_next    = 1'b0;
                pend_valid_next = 1'b0;
            end
            else if (!qstat.empty)
            begin
                out_valid_next  = 1'b1;
                out_unit_next   = first_unit;
                out_last_next   = !is_pair;
                out_eos_next    = pop_data.eos;
                pend_valid_next = is_pair;
                pend_unit_next  = lo_unit;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_unit_reg  <= out_unit_next;
        out_last_reg  <= out_last_next;
        out_eos_reg   <= out_eos_next;
        pend_unit_reg <= pend_unit_next;
    end

    assign utf16_unit    = out_unit_reg;
    assign last_of_run   = out_last_reg;
    assign end_of_string = out_eos_reg;
    assign out_valid     = out_valid_reg;

endmodule

[src/u2u_checker.sv]
// Port-level checks for the UTF-8 to UTF-16 transcoder, and the bind that attaches them.
// Depends only on the ports of utf8_to_utf16_stream.
`timescale 1ns / 1ps

module u2u_checker (
    input logic        clk,
    input logic        rst_n,
    input logic [15:0] utf16_unit,
    input logic        last_of_run,
    input logic        end_of_string,
    input logic        out_valid,
    input logic        out_stall
);

    // A held transaction keeps its unit.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(utf16_unit))
        else $error("output unit changed while stalled");

    // The terminator is a lone zero unit.
    a_eos_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> utf16_unit == 16'h0000 && last_of_run)
        else $error("malformed terminator");

    // Only the high half of a pair is not the last unit of its sequence.
    a_first_is_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> utf16_unit[15:10] == 6'b110110 && !end_of_string)
        else $error("non-final unit is not a high surrogate");

    // The low half follows straight after the high half is taken.
    a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=>
            out_valid && last_of_run && utf16_unit[15:10] == 6'b110111)
        else $error("low surrogate did not follow high surrogate");

endmodule

bind utf8_to_utf16_stream u2u_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .utf16_unit    (utf16_unit),
    .last_of_run   (last_of_run),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
);
